### design/assert_macros.svh
// Assertion macros shared by the framer modules.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, disabled while reset is asserted.
`define AUSF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked property that also holds during reset.
`define AUSF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### design/ausf_pkg.sv
// Package for the terminal sequence framer: parse modes, byte codes,
// result record and the UTF-8 lead byte decode. No dependencies.
package ausf_pkg;

  typedef enum logic [2:0] {
    MODE_ASCII = 3'd0,
    MODE_UTF8  = 3'd1,
    MODE_ESC   = 3'd2,
    MODE_CSI   = 3'd3,
    MODE_SS    = 3'd4
  } mode_e;

  localparam logic [7:0] ESC_BYTE        = 8'o033;
  localparam logic [7:0] CONT_LOW        = 8'o200;
  localparam logic [7:0] LEAD_LOW        = 8'o300;
  localparam logic [7:0] INTERMED_LOW    = 8'h20;
  localparam logic [7:0] INTERMED_HIGH   = 8'h2F;
  localparam logic [7:0] CSI_INTRO       = 8'h5B;  // '['
  localparam logic [7:0] SS2_INTRO       = 8'h4E;  // 'N'
  localparam logic [7:0] SS3_INTRO       = 8'h4F;  // 'O'
  localparam logic [7:0] CSI_PARAM_LOW   = 8'h30;  // '0'
  localparam logic [7:0] CSI_PARAM_HIGH  = 8'h3F;  // '?'
  localparam logic [7:0] BUF_SIZE_RESET  = 8'd32;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       seq_end;
    logic [7:0] seq_len;
    logic       overflow;
  } result_t;

  // Bytes that follow a UTF-8 lead byte in the range 0xC0..0xFF.
  function automatic logic [2:0] utf8_followers(input logic [7:0] lead);
    logic [2:0] n;
    if (lead < 8'hE0) begin
      n = 3'd1;
    end else if (lead < 8'hF0) begin
      n = 3'd2;
    end else if (lead < 8'hF8) begin
      n = 3'd3;
    end else if (lead < 8'hFC) begin
      n = 3'd4;
    end else begin
      n = 3'd5;
    end
    return n;
  endfunction

endpackage

### design/ausf_byte_if.sv
// Input channel carrying one raw terminal byte per beat.
// Depends on nothing.
interface ausf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

### design/ausf_cfg_if.sv
// Configuration write channel carrying the buffer_size register value.
// Depends on nothing.
interface ausf_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] buffer_size;

  modport source (output valid, output buffer_size, input ready);
  modport sink (input valid, input buffer_size, output ready);
endinterface

### design/ausf_res_if.sv
// Result channel: echoed byte, sequence end, length and overflow per beat.
// Depends on nothing.
interface ausf_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       seq_end;
  logic [7:0] seq_len;
  logic       overflow;

  modport source (output valid, output out_byte, output seq_end, output seq_len,
                  output overflow, input ready);
  modport sink (input valid, input out_byte, input seq_end, input seq_len,
                input overflow, output ready);
endinterface

### design/ausf_parser.sv
// Per-byte sequence parser: holds mode, UTF-8 count, length and buffer size.
// Depends on ausf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ausf_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_size_i,
  input  logic              acc_i,
  input  logic [7:0]        byte_i,
  output ausf_pkg::result_t res_o
);
  import ausf_pkg::*;

  mode_e      mode_q, mode_d;
  logic [2:0] rem_q, rem_d;
  logic [7:0] count_q, count_d;
  logic [7:0] size_q;
  logic [7:0] len;
  logic       done;
  logic       ovf;
  mode_e      mode_step;
  logic [2:0] rem_step;

  assign len = count_q + 8'd1;

  always_comb begin
    done      = 1'b0;
    mode_step = mode_q;
    rem_step  = rem_q;
    unique case (mode_q)
      MODE_UTF8: begin
        rem_step = rem_q - 3'd1;
        done     = (rem_step == 3'd0);
      end
      MODE_ESC: begin
        if (byte_i == CSI_INTRO) begin
          mode_step = MODE_CSI;
        end else if (byte_i == SS2_INTRO || byte_i == SS3_INTRO) begin
          mode_step = MODE_SS;
        end else if (!(byte_i >= INTERMED_LOW && byte_i <= INTERMED_HIGH)) begin
          done = 1'b1;
        end
      end
      MODE_CSI: begin
        done = !(byte_i >= CSI_PARAM_LOW && byte_i <= CSI_PARAM_HIGH);
      end
      MODE_SS: begin
        done = 1'b1;
      end
      default: begin
        // Plain mode; unused codes behave the same way.
        if (byte_i < CONT_LOW) begin
          if (byte_i == ESC_BYTE) begin
            mode_step = MODE_ESC;
          end else begin
            done = 1'b1;
          end
        end else if (byte_i >= LEAD_LOW) begin
          mode_step = MODE_UTF8;
          rem_step  = utf8_followers(byte_i);
        end
      end
    endcase

    ovf = !done && (({1'b0, len} + 9'd2) >= {1'b0, size_q});

    if (done || ovf) begin
      mode_d  = MODE_ASCII;
      rem_d   = 3'd0;
      count_d = 8'd0;
    end else begin
      mode_d  = mode_step;
      rem_d   = rem_step;
      count_d = len;
    end

    res_o.out_byte = byte_i;
    res_o.seq_end  = done;
    res_o.seq_len  = len;
    res_o.overflow = ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_ASCII;
      rem_q   <= 3'd0;
      count_q <= 8'd0;
      size_q  <= BUF_SIZE_RESET;
    end else begin
      if (acc_i) begin
        mode_q  <= mode_d;
        rem_q   <= rem_d;
        count_q <= count_d;
      end
      if (cfg_we_i) begin
        size_q <= cfg_size_i;
      end
    end
  end

  `AUSF_ASSERT_ALWAYS(a_rem_only_utf8, (mode_q != MODE_UTF8) |-> (rem_q == 3'd0), "utf8 count outside utf8 mode")
  `AUSF_ASSERT(a_end_excl_ovf, acc_i |-> !(res_o.seq_end && res_o.overflow), "end and overflow together")
  `AUSF_ASSERT(a_restart, (acc_i && (res_o.seq_end || res_o.overflow)) |=> (count_q == 8'd0 && mode_q == MODE_ASCII), "parser did not restart")

endmodule

### design/ausf_out_buf.sv
// Two-entry result buffer: output register plus skid register.
// Depends on ausf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ausf_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ausf_pkg::result_t data_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              pop_ready_i,
  output ausf_pkg::result_t data_o
);
  import ausf_pkg::*;

  logic    out_valid_q;
  logic    skid_valid_q;
  result_t out_q;
  result_t skid_q;
  logic    pop;

  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;
  assign pop     = out_valid_q && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || pop) begin
      out_valid_q <= push_i;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || pop) begin
      if (push_i) begin
        out_q <= data_i;
      end
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end

  `AUSF_ASSERT_ALWAYS(a_skid_implies_out, skid_valid_q |-> out_valid_q, "skid holds a beat ahead of output")
  `AUSF_ASSERT(a_no_push_when_full, skid_valid_q |-> !push_i, "beat pushed into full buffer")

endmodule

### design/ansi_utf8_sequence_framer_top.sv
// Top level of the terminal keystroke sequence framer.
// Depends on ausf_pkg, the three channel interfaces, ausf_parser and ausf_out_buf.

// The framer takes one raw terminal byte per input beat and returns one
// result beat for every byte: the byte itself, whether it ends a keystroke
// sequence (plain ASCII, UTF-8 character, ESC, CSI or SS2/SS3 sequence),
// the sequence length so far including this byte, and an overflow flag
// raised when the length reaches buffer_size minus two without an end.
// After an end or an overflow the parser starts over in plain mode.
// Throughput is one byte per clock cycle while the buffer has room: the
// parser updates mode, UTF-8 follower count and length combinationally
// at the input handshake, and the result is registered in the output
// buffer when the byte is accepted. An output register backed by a skid
// register lets the input keep flowing while one result waits; input
// ready drops only when two results are waiting. buffer_size resets to
// 32 and is written through the configuration channel, which is always
// ready; write it only while no sequence is being parsed.

module ansi_utf8_sequence_framer_top (
  input  logic clk_i,
  input  logic rst_ni,
  ausf_cfg_if.sink   cfg_i,
  ausf_byte_if.sink  in_i,
  ausf_res_if.source out_o
);
  import ausf_pkg::*;

  logic    in_acc;
  logic    buf_ready;
  result_t parse_res;
  result_t out_res;

  // Configuration writes are taken in any cycle.
  assign cfg_i.ready = 1'b1;

  assign in_i.ready = buf_ready;
  assign in_acc     = in_i.valid && buf_ready;

  // State update and the result for the accepted byte.
  ausf_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_i.valid),
    .cfg_size_i (cfg_i.buffer_size),
    .acc_i      (in_acc),
    .byte_i     (in_i.in_byte),
    .res_o      (parse_res)
  );

  // Results are registered here so the output side can stall freely.
  ausf_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_acc),
    .data_i      (parse_res),
    .ready_o     (buf_ready),
    .valid_o     (out_o.valid),
    .pop_ready_i (out_o.ready),
    .data_o      (out_res)
  );

  assign out_o.out_byte = out_res.out_byte;
  assign out_o.seq_end  = out_res.seq_end;
  assign out_o.seq_len  = out_res.seq_len;
  assign out_o.overflow = out_res.overflow;

endmodule
